// ===== src/tts_pkg.sv =====
// Shared types and codes for the tick task scheduler.
// No dependencies; imported by every module of the block.
package tts_pkg;

  typedef enum logic [3:0] {
    ACT_INIT         = 4'd0,
    ACT_CREATE       = 4'd1,
    ACT_CREATE_START = 4'd2,
    ACT_SET_EXTRA    = 4'd3,
    ACT_SET_DUE      = 4'd4,
    ACT_SET_DELAY    = 4'd5,
    ACT_AWAKE        = 4'd6,
    ACT_SLEEP        = 4'd7,
    ACT_UPDATE       = 4'd8
  } action_t;

  localparam logic [1:0] KIND_ONESHOT     = 2'd0;
  localparam logic [1:0] KIND_PERIODIC    = 2'd1;
  localparam logic [1:0] KIND_CONDITIONAL = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_QUEUE_FULL  = 2'd1;
  localparam logic [1:0] ST_NOT_CREATED = 2'd2;

  localparam logic [4:0] MAX_REPORTS = 5'd16;

  typedef struct packed {
    logic [3:0]  action;
    logic [3:0]  task_index;
    logic [1:0]  task_kind;
    logic        has_callback;
    logic [31:0] value;
    logic        condition_present;
    logic [31:0] now;
    logic [15:0] condition_flags;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] task_index_res;
    logic       fired;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_RD,
    S_EVAL,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic rd;
    logic eval;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic scan_go;
    logic out_free;
    logic eval_block;
    logic scan_last;
  } sts_t;

endpackage

// ===== src/tts_ctrl.sv =====
// Controller state machine of the tick task scheduler.
// Depends on tts_pkg; drives commands to tts_dpath.
module tts_ctrl import tts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        if (sts.scan_go) begin
          state_nxt = S_RD;
        end else if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!sts.eval_block) begin
          cmd.eval  = 1'b1;
          state_nxt = sts.scan_last ? S_FIN : S_RD;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== src/tts_dpath.sv =====
// Datapath of the tick task scheduler: task table, due/period memories,
// scan pointer, pending fire report and output register. Depends on tts_pkg.
module tts_dpath import tts_pkg::*; #(
  parameter int          QUEUE_SIZE   = 16,
  parameter logic [31:0] PERIOD_LIMIT = 32'd2147483647
) (
  input  logic clk,
  input  logic rst_n,
  input  in_t  in_data,
  input  cmd_t cmd,
  output sts_t sts,
  input  logic out_stall,
  output logic out_valid,
  output out_t out_data
);

  localparam int IDX_W = (QUEUE_SIZE > 1) ? $clog2(QUEUE_SIZE) : 1;
  localparam int CNT_W = $clog2(QUEUE_SIZE + 1);
  localparam logic [CNT_W-1:0] QS_CNT = CNT_W'(QUEUE_SIZE);

  in_t              item_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      prev_r, prev_nxt;
  logic [1:0]       kind_r [QUEUE_SIZE];
  logic [QUEUE_SIZE-1:0] awake_r, cb_r, cv_r, pv_r;
  logic [QUEUE_SIZE-1:0] awake_nxt, cb_nxt, cv_nxt, pv_nxt;
  logic [1:0]       kind_nxt;
  logic             kind_we;
  logic [IDX_W-1:0] kind_addr;

  logic [31:0]      due_mem [QUEUE_SIZE];
  logic [30:0]      per_mem [QUEUE_SIZE];
  logic             due_we, per_we;
  logic [IDX_W-1:0] due_addr, per_addr;
  logic [31:0]      due_wdata;
  logic [30:0]      per_wdata;
  logic [31:0]      rd_due_r;
  logic [30:0]      rd_per_r;

  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [4:0]       nrep_r, nrep_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [3:0]       pend_idx_r, pend_idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;
  logic             out_free, emit;

  logic [7:0]       ti_ext, scan_ext;
  logic [IDX_W-1:0] cmd_addr, slot;
  logic             idx_ok, full, val_period_ok;
  logic [1:0]       new_kind, cur_kind;
  logic [31:0]      diff;
  logic             act, cbit, fire, rep;

  assign out_free      = !out_valid_r || !out_stall;
  assign ti_ext        = 8'(item_r.task_index);
  assign scan_ext      = 8'(scan_r);
  assign cmd_addr      = ti_ext[IDX_W-1:0];
  assign slot          = count_r[IDX_W-1:0];
  assign idx_ok        = (CNT_W + 4)'(item_r.task_index) < (CNT_W + 4)'(count_r);
  assign full          = (count_r >= QS_CNT);
  assign val_period_ok = (item_r.value != 32'd0) && (item_r.value <= PERIOD_LIMIT);
  assign new_kind      = (item_r.task_kind == 2'd3) ? KIND_ONESHOT : item_r.task_kind;
  assign cur_kind      = kind_r[scan_r];

  // scan evaluation for entry scan_r, using registered memory reads
  assign diff = item_r.now - rd_due_r;
  assign act  = awake_r[scan_r] && cb_r[scan_r];
  assign cbit = (scan_ext < 8'd16) ? item_r.condition_flags[scan_ext[3:0]] : 1'b0;
  always_comb begin
    if (cur_kind == KIND_CONDITIONAL) begin
      fire = act && cv_r[scan_r] && cbit;
    end else begin
      fire = act && !diff[31];
    end
  end
  assign rep = fire && (nrep_r < MAX_REPORTS);

  assign sts.scan_go    = (item_r.action == ACT_UPDATE) && (item_r.now != prev_r)
                          && (count_r != '0);
  assign sts.out_free   = out_free;
  assign sts.eval_block = rep && pend_v_r && !out_free;
  assign sts.scan_last  = ((CNT_W + 1)'(scan_r) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(count_r);

  always_comb begin
    count_nxt    = count_r;
    prev_nxt     = prev_r;
    awake_nxt    = awake_r;
    cb_nxt       = cb_r;
    cv_nxt       = cv_r;
    pv_nxt       = pv_r;
    kind_we      = 1'b0;
    kind_addr    = slot;
    kind_nxt     = new_kind;
    due_we       = 1'b0;
    due_addr     = cmd_addr;
    due_wdata    = item_r.value;
    per_we       = 1'b0;
    per_addr     = cmd_addr;
    per_wdata    = item_r.value[30:0];
    scan_nxt     = scan_r;
    nrep_nxt     = nrep_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    emit         = 1'b0;
    out_nxt      = '{status: ST_OK, task_index_res: 4'd0, fired: 1'b0, last: 1'b1};

    if (cmd.load) begin
      scan_nxt   = '0;
      nrep_nxt   = '0;
      pend_v_nxt = 1'b0;
    end

    if (cmd.exec) begin
      emit = 1'b1;
      unique case (item_r.action)
        ACT_INIT: begin
          count_nxt = '0;
          prev_nxt  = item_r.now - 32'd1;
        end
        ACT_CREATE, ACT_CREATE_START: begin
          if (full) begin
            out_nxt.status = ST_QUEUE_FULL;
          end else begin
            count_nxt       = count_r + CNT_W'(1);
            kind_we         = 1'b1;
            cb_nxt[slot]    = item_r.has_callback;
            due_we          = 1'b1;
            due_addr        = slot;
            per_addr        = slot;
            out_nxt.task_index_res = ti_ext[3:0] ^ ti_ext[3:0] ^ 4'(count_r);
            if (item_r.action == ACT_CREATE_START) begin
              due_wdata       = item_r.now;
              awake_nxt[slot] = 1'b1;
              if (new_kind == KIND_PERIODIC && val_period_ok) begin
                per_we       = 1'b1;
                pv_nxt[slot] = 1'b1;
              end
              if (new_kind == KIND_CONDITIONAL && item_r.condition_present) begin
                cv_nxt[slot] = 1'b1;
              end
            end else begin
              due_wdata       = 32'hFFFF_FFFF;
              awake_nxt[slot] = 1'b0;
            end
          end
        end
        ACT_SET_EXTRA, ACT_SET_DUE, ACT_SET_DELAY, ACT_AWAKE, ACT_SLEEP: begin
          if (!idx_ok) begin
            out_nxt.status = ST_NOT_CREATED;
          end else begin
            unique case (item_r.action)
              ACT_SET_EXTRA: begin
                if (kind_r[cmd_addr] == KIND_PERIODIC && val_period_ok) begin
                  per_we           = 1'b1;
                  pv_nxt[cmd_addr] = 1'b1;
                end
                if (kind_r[cmd_addr] == KIND_CONDITIONAL && item_r.condition_present) begin
                  cv_nxt[cmd_addr] = 1'b1;
                end
              end
              ACT_SET_DUE:   due_we = 1'b1;
              ACT_SET_DELAY: begin
                due_we    = 1'b1;
                due_wdata = item_r.now + item_r.value;
              end
              ACT_AWAKE:     awake_nxt[cmd_addr] = 1'b1;
              default:       awake_nxt[cmd_addr] = 1'b0;
            endcase
          end
        end
        ACT_UPDATE: prev_nxt = item_r.now;
        default: ;
      endcase
    end

    if (cmd.eval) begin
      scan_nxt = scan_r + IDX_W'(1);
      if (fire) begin
        if (cur_kind == KIND_PERIODIC && pv_r[scan_r]) begin
          due_we    = 1'b1;
          due_addr  = scan_r;
          due_wdata = rd_due_r + {1'b0, rd_per_r};
        end else begin
          awake_nxt[scan_r] = 1'b0;
        end
      end
      if (rep) begin
        if (pend_v_r) begin
          emit    = 1'b1;
          out_nxt = '{status: ST_OK, task_index_res: pend_idx_r, fired: 1'b1, last: 1'b0};
        end
        pend_v_nxt   = 1'b1;
        pend_idx_nxt = scan_ext[3:0];
        nrep_nxt     = nrep_r + 5'd1;
      end
    end

    if (cmd.fin) begin
      emit     = 1'b1;
      prev_nxt = item_r.now;
      if (pend_v_r) begin
        out_nxt = '{status: ST_OK, task_index_res: pend_idx_r, fired: 1'b1, last: 1'b1};
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      prev_r      <= '0;
      awake_r     <= '0;
      cb_r        <= '0;
      cv_r        <= '0;
      pv_r        <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      nrep_r      <= '0;
      for (int i = 0; i < QUEUE_SIZE; i++) begin
        kind_r[i] <= KIND_ONESHOT;
      end
    end else begin
      count_r     <= count_nxt;
      prev_r      <= prev_nxt;
      awake_r     <= awake_nxt;
      cb_r        <= cb_nxt;
      cv_r        <= cv_nxt;
      pv_r        <= pv_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      scan_r      <= scan_nxt;
      nrep_r      <= nrep_nxt;
      if (kind_we) begin
        kind_r[kind_addr] <= kind_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (emit) begin
      out_r <= out_nxt;
    end
    pend_idx_r <= pend_idx_nxt;
  end

  // task memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (due_we) begin
      due_mem[due_addr] <= due_wdata;
    end
    if (per_we) begin
      per_mem[per_addr] <= per_wdata;
    end
    if (cmd.rd) begin
      rd_due_r <= due_mem[scan_r];
      rd_per_r <= per_mem[scan_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== src/tick_task_scheduler_core.sv =====
// Tick task scheduler: one command beat at a time, result in an output register.
// Non-update commands: the beat is loaded, then executed once the output register is free;
// the result is registered. Update with a new tick and at least one task: each task entry
// takes a memory read step and an evaluate step, plus waits while a fire report is
// stalled. Update with the same tick or an empty table is executed like any command.
// Reset (rst_n low, synchronous) clears the task count, the tick and all task flags.
// Depends on tts_pkg, tts_ctrl and tts_dpath.
module tick_task_scheduler_core import tts_pkg::*; #(
  parameter int          QUEUE_SIZE   = 16,
  parameter logic [31:0] PERIOD_LIMIT = 32'd2147483647
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  cmd_t cmd;
  sts_t sts;

  // controller sequences each beat; datapath holds the table and reports fires
  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tts_dpath #(
    .QUEUE_SIZE   (QUEUE_SIZE),
    .PERIOD_LIMIT (PERIOD_LIMIT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
